// ----- hdl/cmhp_pkg.sv -----
// Shared types, constants and helpers of the caption management header parser.
`default_nettype none
package cmhp_pkg;

    // Default configuration.
    localparam int MAX_LANGUAGES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Most results that one header byte can produce.
    localparam int MAX_RESULTS = 3;

    // Field kinds of a result.
    localparam logic [3:0] KIND_MODE      = 4'd0;
    localparam logic [3:0] KIND_OFFSET    = 4'd1;
    localparam logic [3:0] KIND_COUNT     = 4'd2;
    localparam logic [3:0] KIND_TAG       = 4'd3;
    localparam logic [3:0] KIND_DISP_MODE = 4'd4;
    localparam logic [3:0] KIND_CONDITION = 4'd5;
    localparam logic [3:0] KIND_LANG_CODE = 4'd6;
    localparam logic [3:0] KIND_FORMAT    = 4'd7;
    localparam logic [3:0] KIND_CODING    = 4'd8;
    localparam logic [3:0] KIND_ROLLUP    = 4'd9;
    localparam logic [3:0] KIND_LENGTH    = 4'd10;
    localparam logic [3:0] KIND_ERROR     = 4'd11;

    // Header code values.
    localparam logic [1:0] TMD_OFFSET   = 2'h2;
    localparam logic [3:0] DMF_COND_LO  = 4'hC;
    localparam logic [3:0] DMF_COND_MID = 4'hD;
    localparam logic [3:0] DMF_COND_HI  = 4'hE;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    // Last byte position inside the offset time and the 24-bit fields.
    localparam logic [2:0] OTM_LAST_BYTE  = 3'd4;
    localparam logic [2:0] WIDE_LAST_BYTE = 3'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OTM,
        PH_COUNT,
        PH_TAG,
        PH_CODE,
        PH_FMT,
        PH_LEN,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  index;
        logic [23:0] value;
        logic        last;
    } t_result;

    // All the results that one header byte produces, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                   num;
        t_result [MAX_RESULTS-1:0]    res;
    } t_job;

    function automatic t_result mk_result(input logic [3:0] kind, input logic [3:0] index,
                                          input logic [23:0] value, input logic last);
        t_result r;
        r.kind  = kind;
        r.index = index;
        r.value = value;
        r.last  = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/cmhp_front.sv -----
// Front part: takes header bytes, tracks the header layout and builds result requests.
`default_nettype none
module cmhp_front
    import cmhp_pkg::*;
#(
    parameter int MAX_LANGUAGES = MAX_LANGUAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_start_req,
    input  wire logic       i_queue_full,
    output t_job            o_job,
    output logic            o_job_push
);

    localparam logic [7:0] MAX_LANG_B = 8'(MAX_LANGUAGES);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_byte, n_byte;
    logic [7:0]  r_total, n_total;
    logic [3:0]  r_lang, n_lang;
    logic        r_cond, n_cond;
    logic [23:0] r_acc, n_acc;

    logic        accept;
    logic [3:0]  lang_inc;
    logic [3:0]  dmf;
    logic [23:0] acc_shift;
    t_job        job;

    assign accept    = i_push && !i_queue_full;
    assign lang_inc  = r_lang + 4'd1;
    assign dmf       = i_data_byte[3:0];
    assign acc_shift = {r_acc[15:0], i_data_byte};

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_start_req) begin
                n_phase = (i_data_byte[7:6] == TMD_OFFSET) ? PH_OTM : PH_COUNT;
            end else begin
                case (r_phase)
                    PH_OTM: begin
                        if (r_byte >= OTM_LAST_BYTE) n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        if (i_data_byte > MAX_LANG_B) n_phase = PH_DONE;
                        else if (i_data_byte == 8'd0) n_phase = PH_LEN;
                        else n_phase = PH_TAG;
                    end
                    PH_TAG: n_phase = PH_CODE;
                    PH_CODE: begin
                        if (!r_cond && r_byte >= WIDE_LAST_BYTE) n_phase = PH_FMT;
                    end
                    PH_FMT: begin
                        n_phase = ({4'd0, lang_inc} >= r_total) ? PH_LEN : PH_TAG;
                    end
                    PH_LEN: begin
                        if (r_byte >= WIDE_LAST_BYTE) n_phase = PH_DONE;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // Field decoding and working registers.
    always_comb begin
        n_byte  = r_byte;
        n_total = r_total;
        n_lang  = r_lang;
        n_cond  = r_cond;
        n_acc   = r_acc;
        job     = '0;
        if (accept) begin
            if (i_start_req) begin
                n_byte  = '0;
                n_total = '0;
                n_lang  = '0;
                n_cond  = 1'b0;
                n_acc   = '0;
                job.num = 2'd1;
                job.res[0] = mk_result(KIND_MODE, 4'd0, {22'd0, i_data_byte[7:6]}, 1'b0);
            end else begin
                case (r_phase)
                    PH_OTM: begin
                        job.res[0] = mk_result(KIND_OFFSET, {r_byte, 1'b0},
                                               {20'd0, i_data_byte[7:4]}, 1'b0);
                        if (r_byte < OTM_LAST_BYTE) begin
                            job.res[1] = mk_result(KIND_OFFSET, {r_byte, 1'b1},
                                                   {20'd0, i_data_byte[3:0] & NIBBLE_MASK},
                                                   1'b0);
                            job.num = 2'd2;
                            n_byte  = r_byte + 3'd1;
                        end else begin
                            job.num = 2'd1;
                            n_byte  = '0;
                        end
                    end
                    PH_COUNT: begin
                        n_total    = i_data_byte;
                        job.res[0] = mk_result(KIND_COUNT, 4'd0, {16'd0, i_data_byte}, 1'b0);
                        if (i_data_byte > MAX_LANG_B) begin
                            job.res[1] = mk_result(KIND_ERROR, 4'd0, {16'd0, i_data_byte}, 1'b1);
                            job.num    = 2'd2;
                        end else begin
                            job.num = 2'd1;
                            n_lang  = '0;
                            n_byte  = '0;
                            n_acc   = '0;
                        end
                    end
                    PH_TAG: begin
                        job.res[0] = mk_result(KIND_TAG, r_lang, {21'd0, i_data_byte[7:5]}, 1'b0);
                        job.res[1] = mk_result(KIND_DISP_MODE, r_lang, {20'd0, dmf}, 1'b0);
                        job.num    = 2'd2;
                        n_cond     = (dmf == DMF_COND_LO) || (dmf == DMF_COND_MID) ||
                                     (dmf == DMF_COND_HI);
                        n_byte     = '0;
                        n_acc      = '0;
                    end
                    PH_CODE: begin
                        if (r_cond) begin
                            n_cond     = 1'b0;
                            job.res[0] = mk_result(KIND_CONDITION, r_lang,
                                                   {16'd0, i_data_byte}, 1'b0);
                            job.num    = 2'd1;
                        end else if (r_byte < WIDE_LAST_BYTE) begin
                            n_acc  = acc_shift;
                            n_byte = r_byte + 3'd1;
                        end else begin
                            job.res[0] = mk_result(KIND_LANG_CODE, r_lang, acc_shift, 1'b0);
                            job.num    = 2'd1;
                            n_byte     = '0;
                            n_acc      = '0;
                        end
                    end
                    PH_FMT: begin
                        job.res[0] = mk_result(KIND_FORMAT, r_lang,
                                               {20'd0, i_data_byte[7:4]}, 1'b0);
                        job.res[1] = mk_result(KIND_CODING, r_lang,
                                               {22'd0, i_data_byte[3:2]}, 1'b0);
                        job.res[2] = mk_result(KIND_ROLLUP, r_lang,
                                               {22'd0, i_data_byte[1:0]}, 1'b0);
                        job.num    = 2'd3;
                        n_lang     = lang_inc;
                        n_byte     = '0;
                        n_acc      = '0;
                    end
                    PH_LEN: begin
                        n_acc = acc_shift;
                        if (r_byte < WIDE_LAST_BYTE) begin
                            n_byte = r_byte + 3'd1;
                        end else begin
                            job.res[0] = mk_result(KIND_LENGTH, 4'd0, acc_shift, 1'b1);
                            job.num    = 2'd1;
                            n_byte     = '0;
                        end
                    end
                    default: job = '0;
                endcase
            end
        end
    end

    assign o_job      = job;
    assign o_job_push = accept && (job.num != 2'd0);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_byte  <= '0;
            r_total <= '0;
            r_lang  <= '0;
            r_cond  <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_byte  <= n_byte;
            r_total <= n_total;
            r_lang  <= n_lang;
            r_cond  <= n_cond;
            r_acc   <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/cmhp_fifo.sv -----
// Short request queue between the front and back parts, held in flip-flops.
`default_nettype none
module cmhp_fifo
    import cmhp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_wr_data,
    output logic      o_full,
    input  wire logic i_rd,
    output t_job      o_rd_data,
    output logic      o_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_wr, do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        if (do_rd) n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        if (do_wr && !do_rd) n_count = r_count + CW'(1);
        else if (!do_wr && do_rd) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_wr_data;
    end

endmodule
`default_nettype wire

// ----- hdl/cmhp_back.sv -----
// Back part: holds one request and hands out its results one per pop.
`default_nettype none
module cmhp_back
    import cmhp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_job   i_job,
    input  wire logic   i_job_valid,
    output logic        o_job_take,
    input  wire logic   i_pop,
    output logic        o_empty,
    output logic [3:0]  o_field_kind,
    output logic [3:0]  o_index,
    output logic [23:0] o_field_value,
    output logic        o_last_field
);

    logic       r_valid, n_valid;
    t_job       r_job, n_job;
    logic [1:0] r_slot, n_slot;
    logic       last_slot, taken, load;
    t_result    cur;

    assign last_slot = (r_slot == r_job.num - 2'd1);
    assign taken     = i_pop && r_valid;
    assign load      = i_job_valid && (!r_valid || (taken && last_slot));
    assign cur       = r_job.res[r_slot];

    // Advance through the slots of the held request, loading the next one when done.
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        n_slot  = r_slot;
        if (load) begin
            n_valid = 1'b1;
            n_job   = i_job;
            n_slot  = '0;
        end else if (taken) begin
            if (last_slot) n_valid = 1'b0;
            else n_slot = r_slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else begin
            r_valid <= n_valid;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_job_take    = load;
    assign o_empty       = !r_valid;
    assign o_field_kind  = cur.kind;
    assign o_index       = cur.index;
    assign o_field_value = cur.value;
    assign o_last_field  = cur.last;

endmodule
`default_nettype wire

// ----- hdl/caption_management_header_parser_top.sv -----
// Top level of the caption management data header parser.
//
// Input channel: one header byte per request on i_data_byte, with i_start_req
// high on the time control mode byte that opens a header. A request is taken
// when i_push is high and o_full is low.
// Result channel: decoded fields (kind, index, value, last flag) appear while
// o_empty is low and leave on a cycle with i_pop high.
// A byte's results are written into the request queue when the byte is taken
// and move on to the result stage, a register, once that stage is free.
// Throughput: one byte per cycle as long as the results keep pace; a byte
// that yields two or three fields occupies the result side until all are
// popped, and the four-entry request queue absorbs such bursts.
// Bytes before a start marker or after the header produce nothing.
// When the receiver stalls, the result holds and the queue fills; o_full then
// holds off further bytes without losing any.
// Reset (synchronous, active low) returns the parser to waiting for a start
// marker and empties the queue and the result stage.
`default_nettype none
module caption_management_header_parser_top
    import cmhp_pkg::*;
#(
    parameter int MAX_LANGUAGES = MAX_LANGUAGES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_req,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [3:0]       o_field_kind,
    output logic [3:0]       o_index,
    output logic [23:0]      o_field_value,
    output logic             o_last_field
);

    t_job wr_job, rd_job;
    logic wr_push, q_full, q_valid, q_take;

    assign o_full = q_full;

    // Byte parsing.
    cmhp_front #(.MAX_LANGUAGES(MAX_LANGUAGES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_data_byte  (i_data_byte),
        .i_start_req  (i_start_req),
        .i_queue_full (q_full),
        .o_job        (wr_job),
        .o_job_push   (wr_push)
    );

    // Decoupling queue.
    cmhp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_push),
        .i_wr_data (wr_job),
        .o_full    (q_full),
        .i_rd      (q_take),
        .o_rd_data (rd_job),
        .o_valid   (q_valid)
    );

    // Result delivery.
    cmhp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (rd_job),
        .i_job_valid   (q_valid),
        .o_job_take    (q_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_field_kind  (o_field_kind),
        .o_index       (o_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field)
    );

endmodule
`default_nettype wire

// ----- hdl/cmhp_checker.sv -----
// Port-level checks on the header parser, bound to its top level.
`default_nettype none
module cmhp_checker
    import cmhp_pkg::*;
#(
    parameter int MAX_LANGUAGES = MAX_LANGUAGES_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_pop,
    input wire logic        o_empty,
    input wire logic [3:0]  o_field_kind,
    input wire logic [3:0]  o_index,
    input wire logic [23:0] o_field_value,
    input wire logic        o_last_field
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result shown right after reset");

    // A waiting result is not withdrawn or changed while it is not popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_field_kind) && $stable(o_index)
                                  && $stable(o_field_value) && $stable(o_last_field)))
        else $error("stalled result changed");

    // Only the loop length or an error ends a header.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last_field) |->
            (o_field_kind == KIND_LENGTH || o_field_kind == KIND_ERROR))
        else $error("last flag on a field that does not end the header");

    // Offset digit positions stay within the nine digits.
    a_digit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_field_kind == KIND_OFFSET) |-> (o_index <= 4'd8))
        else $error("offset digit position out of range");

    // An error reports a count above the limit and is always last.
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_field_kind == KIND_ERROR) |->
            (o_last_field && o_field_value > 24'(MAX_LANGUAGES)))
        else $error("error result without an over-limit count");

endmodule

bind caption_management_header_parser_top cmhp_checker #(
    .MAX_LANGUAGES(MAX_LANGUAGES)
) u_cmhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pop         (i_pop),
    .o_empty       (o_empty),
    .o_field_kind  (o_field_kind),
    .o_index       (o_index),
    .o_field_value (o_field_value),
    .o_last_field  (o_last_field)
);
`default_nettype wire
